[design/rcfs_pkg.sv]
// Shared constants, types and helper functions of the RC frame sync receiver.
`default_nettype none
package rcfs_pkg;
	localparam int WINDOW_BYTES  = 64;
	localparam int PAYLOAD_BYTES = 22;
	localparam int WIN_AW        = $clog2(WINDOW_BYTES);
	localparam int LEN_W         = WIN_AW + 1;
	localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
	localparam int CFG_IDX_W     = 2;

	localparam logic [7:0] CRC_TOP_BIT = 8'h80;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_A  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_B  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY   = 2'd3;

	localparam logic [7:0] RST_ADDRESS_A  = 8'd200;
	localparam logic [7:0] RST_ADDRESS_B  = 8'd238;
	localparam logic [7:0] RST_FRAME_TYPE = 8'd22;
	localparam logic [7:0] RST_CRC_POLY   = 8'd213;

	// no length captured
	localparam logic [LEN_W-1:0] LEN_NONE = LEN_W'(WINDOW_BYTES);

	typedef struct packed {
		logic clear;
		logic step;
	} crc_ctrl_t;

	// one byte of CRC-8, MSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
	                                        input logic [7:0] data,
	                                        input logic [7:0] poly);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int b = 0; b < 8; b++) begin
			if ((c & CRC_TOP_BIT) != 8'h00) c = {c[6:0], 1'b0} ^ poly;
			else c = {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic is_address(input logic [7:0] b,
	                                    input logic [7:0] addr_a,
	                                    input logic [7:0] addr_b);
		return (b == addr_a) || (b == addr_b);
	endfunction
endpackage
`default_nettype wire

[design/rc_frame_sync_crc8_receiver.sv]
// RC frame sync receiver: byte window, length capture, CRC scan and payload output.
//
// Usage:
//  - s_axis carries one received serial byte per transaction (tdata[7:0] = rx_byte).
//  - m_axis carries one decoded RC channel frame per transaction; tdata holds the
//    22 payload bytes, byte 0 in bits 7:0 (payload_low 63:0, payload_mid 127:64,
//    payload_high 175:128).
//  - cfg_we/cfg_index/cfg_wdata write address_a, address_b, channel_frame_type and
//    crc_polynomial; write only while s_axis_tready is high and no byte is pending.
// Timing:
//  - A byte with no usable captured length (none, or outside 23..62) leaves the
//    sequencer idle; s_axis_tready stays high.
//  - Otherwise the sequencer walks the window once through the single read port of
//    the window memory, feeding the shared CRC unit one byte per cycle: L+2 reads,
//    then the drain and check states; check waits while the output is stalled.
//  - A matching frame shows on m_axis in the cycle after the check.
// Reset: window reads as zeros, no length captured, registers at defaults.
// Stall: the result waits in the output register; a new byte is still accepted,
// but the next result is not loaded until the held transaction completes.
`default_nettype none
module rc_frame_sync_crc8_receiver (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [7:0]                       s_axis_tdata,  // [7:0] rx_byte
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [63:0] payload_low, [127:64] payload_mid, [175:128] payload_high
	output logic [rcfs_pkg::PAYLOAD_W-1:0]        m_axis_tdata,
	input  wire logic                             cfg_we,
	input  wire logic [rcfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [7:0]                       cfg_wdata
);
	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_CHECK} state_t;

	localparam int AW = rcfs_pkg::WIN_AW;
	localparam int LW = rcfs_pkg::LEN_W;

	state_t                       state_q;
	logic [7:0]                   addr_a_q, addr_b_q, frame_type_q, crc_poly_q;
	logic [LW-1:0]                frame_len_q;   // captured length
	logic [AW-1:0]                run_len_q;     // length used by the current scan
	logic [7:0]                   last_byte_q;
	logic [AW-1:0]                base_q;        // memory address of the address byte
	logic [AW-1:0]                pos_q;         // scan position, issue side
	logic [AW-1:0]                pos_s1;        // scan position, data side
	logic                         rd_v_s1;
	logic                         addr_ok_q, type_ok_q;
	logic [rcfs_pkg::PAYLOAD_W-1:0] payload_q;
	logic                         out_valid_q;
	logic [rcfs_pkg::PAYLOAD_W-1:0] out_data_q;

	logic                         accept;
	logic                         len_usable;
	logic [AW-1:0]                wr_ptr;
	logic [AW-1:0]                scan_start;
	logic [7:0]                   rd_byte;
	logic [7:0]                   crc;
	rcfs_pkg::crc_ctrl_t          crc_ctrl;
	logic                         match;
	logic                         out_free;
	logic                         load_out;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign len_usable    = (frame_len_q >= LW'(rcfs_pkg::PAYLOAD_BYTES + 1)) &&
	                       (frame_len_q <= LW'(rcfs_pkg::WINDOW_BYTES - 2));
	// window index of the address byte: WINDOW_BYTES - L - 2
	assign scan_start    = AW'(rcfs_pkg::WINDOW_BYTES - 2) - frame_len_q[AW-1:0];

	rcfs_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (s_axis_tdata),
		.rd_addr (base_q + pos_q),
		.wr_ptr  (wr_ptr),
		.rd_byte (rd_byte)
	);

	// CRC covers type, payload and crc bytes: scan positions 2 and up
	always_comb begin
		crc_ctrl.clear = accept;
		crc_ctrl.step  = rd_v_s1 && (pos_s1 >= AW'(2));
	end

	rcfs_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.data   (rd_byte),
		.poly   (crc_poly_q),
		.crc    (crc)
	);

	assign match    = (crc == 8'h00) && addr_ok_q && type_ok_q;
	assign out_free = !out_valid_q || m_axis_tready;
	assign load_out = (state_q == ST_CHECK) && out_free && match;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_a_q     <= rcfs_pkg::RST_ADDRESS_A;
			addr_b_q     <= rcfs_pkg::RST_ADDRESS_B;
			frame_type_q <= rcfs_pkg::RST_FRAME_TYPE;
			crc_poly_q   <= rcfs_pkg::RST_CRC_POLY;
		end else if (cfg_we) begin
			case (cfg_index)
				rcfs_pkg::REG_ADDRESS_A:  addr_a_q     <= cfg_wdata;
				rcfs_pkg::REG_ADDRESS_B:  addr_b_q     <= cfg_wdata;
				rcfs_pkg::REG_FRAME_TYPE: frame_type_q <= cfg_wdata;
				rcfs_pkg::REG_CRC_POLY:   crc_poly_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer, length capture and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			frame_len_q <= rcfs_pkg::LEN_NONE;
			run_len_q   <= '0;
			last_byte_q <= 8'h00;
			base_q      <= '0;
			pos_q       <= '0;
			pos_s1      <= '0;
			rd_v_s1     <= 1'b0;
			addr_ok_q   <= 1'b0;
			type_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			rd_v_s1 <= (state_q == ST_SCAN);
			pos_s1  <= pos_q;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_byte_q <= s_axis_tdata;
						// capture the length byte that follows an address byte
						if (!rcfs_pkg::is_address(s_axis_tdata, addr_a_q, addr_b_q) &&
						    rcfs_pkg::is_address(last_byte_q, addr_a_q, addr_b_q)) begin
							if (s_axis_tdata >= 8'(rcfs_pkg::WINDOW_BYTES))
								frame_len_q <= rcfs_pkg::LEN_NONE;
							else
								frame_len_q <= LW'(s_axis_tdata);
						end
						run_len_q <= frame_len_q[AW-1:0];
						// oldest byte sits one above the newest
						base_q    <= wr_ptr + AW'(2) + scan_start;
						pos_q     <= '0;
						if (len_usable) state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// positions 0..L+1: address, length, type, payload, crc
					if (pos_q == run_len_q + AW'(1)) state_q <= ST_DRAIN;
					else pos_q <= pos_q + AW'(1);
				end
				ST_DRAIN: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (out_free) begin
						if (match) out_data_q <= payload_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (rd_v_s1) begin
				if (pos_s1 == AW'(0))
					addr_ok_q <= rcfs_pkg::is_address(rd_byte, addr_a_q, addr_b_q);
				if (pos_s1 == AW'(2))
					type_ok_q <= (rd_byte == frame_type_q);
			end
		end
	end

	// payload bytes land at the top and move down; byte 0 ends in bits 7:0
	always_ff @(posedge clk) begin
		if (rd_v_s1 && (pos_s1 >= AW'(3)) &&
		    (pos_s1 <= AW'(rcfs_pkg::PAYLOAD_BYTES + 2)))
			payload_q <= {rd_byte, payload_q[rcfs_pkg::PAYLOAD_W-1:8]};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
endmodule
`default_nettype wire

[design/rcfs_window.sv]
// Circular byte window memory with per-entry valid bits and registered read.
`default_nettype none
module rcfs_window (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire logic [7:0]                 wr_data,
	input  wire logic [rcfs_pkg::WIN_AW-1:0] rd_addr,
	output logic [rcfs_pkg::WIN_AW-1:0]      wr_ptr,
	output logic [7:0]                      rd_byte
);
	logic [7:0]                        mem [rcfs_pkg::WINDOW_BYTES];
	logic [rcfs_pkg::WINDOW_BYTES-1:0] valid_q;
	logic [rcfs_pkg::WIN_AW-1:0]       ptr_q;
	logic [7:0]                        rd_data_s1;
	logic                              rd_valid_s1;

	// ptr_q addresses the newest byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			valid_q <= '0;
		end else if (wr_en) begin
			ptr_q                   <= ptr_q + 1'b1;
			valid_q[ptr_q + 1'b1]   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[ptr_q + 1'b1] <= wr_data;
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_valid_s1 <= 1'b0;
		else rd_valid_s1 <= valid_q[rd_addr];
	end

	// never-written entries read as zero
	assign rd_byte = rd_valid_s1 ? rd_data_s1 : 8'h00;
	assign wr_ptr  = ptr_q;
endmodule
`default_nettype wire

[design/rcfs_crc_unit.sv]
// Shared CRC-8 accumulator, one byte per step.
`default_nettype none
module rcfs_crc_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rcfs_pkg::crc_ctrl_t ctrl,
	input  wire logic [7:0]          data,
	input  wire logic [7:0]          poly,
	output logic [7:0]               crc
);
	logic [7:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) crc_q <= 8'h00;
		else if (ctrl.clear) crc_q <= 8'h00;
		else if (ctrl.step) crc_q <= rcfs_pkg::crc8_byte(crc_q, data, poly);
	end

	assign crc = crc_q;
endmodule
`default_nettype wire

[design/rcfs_checker.sv]
// Port-level checker of the RC frame sync receiver, bound to the top level.
`default_nettype none
module rcfs_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tready,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [rcfs_pkg::PAYLOAD_W-1:0]   m_axis_tdata
);
	// a stalled result stays offered
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its data
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result data changed while stalled");

	// a new result only follows a window scan, with input closed
	a_result_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready, 1) && !$past(s_axis_tready, 2))
		else $error("result without a preceding scan");

	// the input side reopens no later than a result is offered
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("input still closed when result offered");
endmodule

bind rc_frame_sync_crc8_receiver rcfs_checker u_rcfs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
